// ===== design/hsr_prp_supervision_frame_check_core_assert.svh =====
// Assertion macros for the HSR/PRP supervision frame check core.
// Used by the port-level checker; no other dependencies.
`ifndef HSR_PRP_SUPERVISION_FRAME_CHECK_CORE_ASSERT_SVH
`define HSR_PRP_SUPERVISION_FRAME_CHECK_CORE_ASSERT_SVH

// clocked assertion, masked while reset is asserted
`define HPSFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion that also holds across reset
`define HPSFC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/hpsfc_pkg.sv =====
// Types, constants and helpers for the HSR/PRP supervision frame check.
// No dependencies.
package hpsfc_pkg;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
    } word_t;

    typedef struct packed {
        logic sup_pass;
        logic hsr_tagged;
        logic has_redbox;
    } result_t;

    localparam logic [47:0] SUPERVISION_MAC_RST = 48'd1190154715392;

    localparam logic [15:0] ETYPE_PRP = 16'h88FB;
    localparam logic [15:0] ETYPE_HSR = 16'h892F;

    // byte offsets within the frame
    localparam logic [4:0] MAC_LEN       = 5'd6;
    localparam logic [4:0] ETYPE_HI_POS  = 5'd12;
    localparam logic [4:0] ETYPE_LO_POS  = 5'd13;
    localparam logic [4:0] TLV_AREA_POS  = 5'd14;
    localparam logic [4:0] INNER_HI_POS  = 5'd18;
    localparam logic [4:0] INNER_LO_POS  = 5'd19;
    localparam logic [4:0] PRP_FIRST_TLV = 5'd18;
    localparam logic [4:0] HSR_FIRST_TLV = 5'd24;

    localparam logic [7:0] TLV_END     = 8'd0;
    localparam logic [7:0] TLV_SUP_20  = 8'd20;
    localparam logic [7:0] TLV_SUP_21  = 8'd21;
    localparam logic [7:0] TLV_SUP_22  = 8'd22;
    localparam logic [7:0] TLV_SUP_23  = 8'd23;
    localparam logic [7:0] TLV_REDBOX  = 8'd30;
    localparam logic [7:0] TLV_LEN_MAC = 8'd6;
    localparam logic [7:0] TLV_LEN_DUO = 8'd12;

    // MAC byte at frame offset idx, first byte most significant
    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = mac[47:40];
            3'd1:    b = mac[39:32];
            3'd2:    b = mac[31:24];
            3'd3:    b = mac[23:16];
            3'd4:    b = mac[15:8];
            default: b = mac[7:0];
        endcase
        return b;
    endfunction

endpackage

// ===== design/hpsfc_in_stage.sv =====
// Input register of the supervision frame check: holds one accepted word.
// Depends on hpsfc_pkg.
module hpsfc_in_stage
    import hpsfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_frame_byte,
    input  logic       s_end_of_frame,
    output logic       word_valid,
    output word_t      word,
    input  logic       word_take
);

    logic  vld_reg;
    logic  vld_next;
    word_t word_reg;

    assign s_ready    = !vld_reg || word_take;
    assign word_valid = vld_reg;
    assign word       = word_reg;

    always_comb begin
        vld_next = vld_reg;
        if (s_valid && s_ready) begin
            vld_next = 1'b1;
        end else if (word_take) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg.frame_byte   <= s_frame_byte;
            word_reg.end_of_frame <= s_end_of_frame;
        end
    end

endmodule

// ===== design/hpsfc_parse.sv =====
// Per-frame parser state and checks; one word per cycle unless a last word waits for res_free; verdict on it.
// Depends on hpsfc_pkg.
module hpsfc_parse
    import hpsfc_pkg::*;
#(
    parameter int POSITION_BITS = 11
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [47:0] cfg_wdata,
    input  logic        word_valid,
    input  word_t       word,
    input  logic        res_free,
    output logic        word_take,
    output logic        res_load,
    output result_t     res
);

    localparam int PB = POSITION_BITS;
    localparam int SW = PB + 9;

    logic [47:0]   mac_reg;
    logic [PB-1:0] pos_reg,   pos_next;
    logic          still_reg, still_next;
    logic          hsr_reg,   hsr_next;
    logic [7:0]    hdr_reg,   hdr_next;
    logic [PB-1:0] nto_reg,   nto_next;
    logic          rbx_reg,   rbx_next;
    logic          tail_reg,  tail_next;

    logic [7:0]    b;
    logic [15:0]   etype;
    logic [PB-1:0] first;
    logic [PB:0]   nto_plus1;
    logic [SW-1:0] hop;
    logic          first_ok;
    logic          ok;

    assign word_take = word_valid && (!word.end_of_frame || res_free);
    assign res_load  = word_take && word.end_of_frame;

    assign b         = word.frame_byte;
    assign etype     = {hdr_reg, b};
    assign first     = hsr_reg ? PB'(HSR_FIRST_TLV) : PB'(PRP_FIRST_TLV);
    assign nto_plus1 = {1'b0, nto_reg} + (PB+1)'(1);
    assign hop       = SW'(pos_reg) + SW'(1) + SW'(b);
    assign first_ok  = (hdr_reg == TLV_SUP_20) || (hdr_reg == TLV_SUP_21) ||
                       (hdr_reg == TLV_SUP_22) || (hdr_reg == TLV_SUP_23);

    always_comb begin
        still_next = still_reg;
        hsr_next   = hsr_reg;
        hdr_next   = hdr_reg;
        nto_next   = nto_reg;
        rbx_next   = rbx_reg;
        tail_next  = tail_reg;
        pos_next   = (pos_reg == {PB{1'b1}}) ? pos_reg : pos_reg + PB'(1);

        if (still_reg) begin
            if (pos_reg < PB'(MAC_LEN)) begin
                if (b != mac_byte(mac_reg, pos_reg[2:0])) begin
                    still_next = 1'b0;
                end
            end else if (pos_reg == PB'(ETYPE_HI_POS)) begin
                hdr_next = b;
            end else if (pos_reg == PB'(ETYPE_LO_POS)) begin
                if (etype == ETYPE_PRP) begin
                    nto_next = PB'(PRP_FIRST_TLV);
                end else if (etype == ETYPE_HSR) begin
                    hsr_next = 1'b1;
                    nto_next = PB'(HSR_FIRST_TLV);
                end else begin
                    still_next = 1'b0;
                end
            end else if (pos_reg < PB'(TLV_AREA_POS) || nto_reg == '0 || tail_reg) begin
                still_next = still_reg;
            end else if (hsr_reg && pos_reg == PB'(INNER_HI_POS)) begin
                hdr_next = b;
            end else if (hsr_reg && pos_reg == PB'(INNER_LO_POS)) begin
                if (etype != ETYPE_PRP) begin
                    still_next = 1'b0;
                end
            end else if (pos_reg == nto_reg) begin
                hdr_next = b;
            end else if ({1'b0, pos_reg} == nto_plus1) begin
                if (nto_reg == first) begin
                    if (!first_ok || (b != TLV_LEN_MAC && b != TLV_LEN_DUO)) begin
                        still_next = 1'b0;
                    end else begin
                        nto_next = hop[PB-1:0];
                    end
                end else if (hdr_reg == TLV_REDBOX && !rbx_reg) begin
                    if (b != TLV_LEN_MAC) begin
                        still_next = 1'b0;
                    end else begin
                        rbx_next = 1'b1;
                        nto_next = hop[PB-1:0];
                    end
                end else begin
                    if (hdr_reg == TLV_END && b != TLV_END) begin
                        still_next = 1'b0;
                    end
                    tail_next = 1'b1;
                end
            end
        end
    end

    assign ok             = still_next && tail_next;
    assign res.sup_pass   = ok;
    assign res.hsr_tagged = hsr_next;
    assign res.has_redbox = ok && rbx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_reg <= SUPERVISION_MAC_RST;
        end else if (cfg_we) begin
            mac_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            still_reg <= 1'b1;
            hsr_reg   <= 1'b0;
            hdr_reg   <= '0;
            nto_reg   <= '0;
            rbx_reg   <= 1'b0;
            tail_reg  <= 1'b0;
        end else if (word_take) begin
            if (word.end_of_frame) begin
                pos_reg   <= '0;
                still_reg <= 1'b1;
                hsr_reg   <= 1'b0;
                hdr_reg   <= '0;
                nto_reg   <= '0;
                rbx_reg   <= 1'b0;
                tail_reg  <= 1'b0;
            end else begin
                pos_reg   <= pos_next;
                still_reg <= still_next;
                hsr_reg   <= hsr_next;
                hdr_reg   <= hdr_next;
                nto_reg   <= nto_next;
                rbx_reg   <= rbx_next;
                tail_reg  <= tail_next;
            end
        end
    end

endmodule

// ===== design/hpsfc_out_stage.sv =====
// Result register of the supervision frame check; holds a verdict until taken.
// Depends on hpsfc_pkg.
module hpsfc_out_stage
    import hpsfc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    res_load,
    input  result_t res,
    output logic    res_free,
    output logic    m_valid,
    input  logic    m_ready,
    output logic    m_sup_pass,
    output logic    m_hsr_tagged,
    output logic    m_has_redbox
);

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    assign res_free     = !vld_reg || m_ready;
    assign m_valid      = vld_reg;
    assign m_sup_pass   = res_reg.sup_pass;
    assign m_hsr_tagged = res_reg.hsr_tagged;
    assign m_has_redbox = res_reg.has_redbox;

    always_comb begin
        vld_next = vld_reg;
        if (res_load) begin
            vld_next = 1'b1;
        end else if (m_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

endmodule

// ===== design/hsr_prp_supervision_frame_check_core.sv =====
// Top level of the HSR/PRP supervision frame check.
// Depends on hpsfc_pkg, hpsfc_in_stage, hpsfc_parse, hpsfc_out_stage.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  s_ in    | s_valid / s_ready  | s_frame_byte[7:0], s_end_of_frame
//  m_ out   | m_valid / m_ready  | m_sup_pass, m_hsr_tagged, m_has_redbox
//  cfg      | cfg_we             | cfg_wdata[47:0] (supervision MAC)
//
// One word per cycle unless a held verdict stalls a last word; input register, combinational checks, result register.
// Verdict is loaded into the result register, valid on m_, when the parser takes the last word.
// Synchronous active-low reset clears both stages and the frame state.
// A held verdict stalls only the last word of the next frame; other words keep flowing.
module hsr_prp_supervision_frame_check_core
    import hpsfc_pkg::*;
#(
    parameter int POSITION_BITS = 11
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [47:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_frame_byte,
    input  logic        s_end_of_frame,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_sup_pass,
    output logic        m_hsr_tagged,
    output logic        m_has_redbox
);

    logic    word_valid;
    word_t   word;
    logic    word_take;
    logic    res_load;
    logic    res_free;
    result_t res;

    hpsfc_in_stage u_in (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_byte   (s_frame_byte),
        .s_end_of_frame (s_end_of_frame),
        .word_valid     (word_valid),
        .word           (word),
        .word_take      (word_take)
    );

    hpsfc_parse #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .word_valid (word_valid),
        .word       (word),
        .res_free   (res_free),
        .word_take  (word_take),
        .res_load   (res_load),
        .res        (res)
    );

    hpsfc_out_stage u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .res_load     (res_load),
        .res          (res),
        .res_free     (res_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sup_pass   (m_sup_pass),
        .m_hsr_tagged (m_hsr_tagged),
        .m_has_redbox (m_has_redbox)
    );

endmodule

// ===== design/hpsfc_checker.sv =====
// Port-level checks for the supervision frame check core, bound to the top level.
// Depends on hsr_prp_supervision_frame_check_core_assert.svh.
`include "hsr_prp_supervision_frame_check_core_assert.svh"

module hpsfc_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_sup_pass,
    input logic m_has_redbox
);

    `HPSFC_ASSERT(a_redbox_needs_pass, m_valid |-> (!m_has_redbox || m_sup_pass),
                  "redbox flagged on failed frame")
    `HPSFC_ASSERT(a_out_holds, (m_valid && !m_ready) |=> m_valid,
                  "result dropped before taken")
    `HPSFC_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid,
                      "result valid right after reset")
    `HPSFC_ASSERT(a_ready_when_out_empty, !m_valid |-> s_ready,
                  "input stalled with result slot free")

endmodule

bind hsr_prp_supervision_frame_check_core hpsfc_checker u_hpsfc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sup_pass   (m_sup_pass),
    .m_has_redbox (m_has_redbox)
);
